### design/osm_pkg.sv
// osm_pkg: shared codes for the order-statistic multiset.
// Item kinds, result status codes and the cell operation type.
// No dependencies.
package osm_pkg;

    // Item kinds carried on i_kind
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Result status codes on o_status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Fixed port widths
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 9;
    localparam int COUNT_W = 9;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_COMPACT,
        OP_ROT_L,
        OP_ROT_R
    } t_cell_op;

endpackage

### design/osm_cell.sv
// osm_cell: one slot of the sorted key chain.
// Holds a key and a valid flag, compares against the broadcast key and
// takes data from either neighbour. Depends on osm_pkg.
module osm_cell
    import osm_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_op             i_op,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [KEY_WIDTH-1:0] i_prev_key,
    input  logic                 i_prev_valid,
    input  logic                 i_prev_gt,
    input  logic [KEY_WIDTH-1:0] i_next_key,
    input  logic                 i_next_valid,
    input  logic                 i_chain_end,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic                 o_valid,
    output logic                 o_gt,
    output logic                 o_match
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 r_valid;
    logic                 n_valid;
    logic [KEY_WIDTH-1:0] w_ord_cell;
    logic [KEY_WIDTH-1:0] w_ord_in;
    logic                 w_le;

    // Sign bit flipped so that unsigned compare gives signed order
    assign w_ord_cell = {~r_key[KEY_WIDTH-1], r_key[KEY_WIDTH-2:0]};
    assign w_ord_in   = {~i_key[KEY_WIDTH-1], i_key[KEY_WIDTH-2:0]};

    assign o_gt    = r_valid && (w_ord_cell >= w_ord_in);
    assign w_le    = w_ord_cell <= w_ord_in;
    assign o_match = r_valid && (r_key == i_key);
    assign o_key   = r_key;
    assign o_valid = r_valid;

    // Next contents per operation
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        case (i_op)
            OP_INSERT: begin
                // keys not smaller stay; new key lands at the first smaller or empty slot
                if (!o_gt) begin
                    if (i_prev_gt) begin
                        n_key   = i_key;
                        n_valid = 1'b1;
                    end else begin
                        n_key   = i_prev_key;
                        n_valid = i_prev_valid;
                    end
                end
            end
            OP_COMPACT: begin
                // slots from the first copy onwards close up by one
                if (!r_valid || w_le) begin
                    n_key   = i_next_key;
                    n_valid = i_chain_end ? 1'b0 : i_next_valid;
                end
            end
            OP_ROT_L: begin
                n_key   = i_next_key;
                n_valid = i_next_valid;
            end
            OP_ROT_R: begin
                n_key   = i_prev_key;
                n_valid = i_prev_valid;
            end
            default: begin
                n_key   = r_key;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

### design/osm_ctrl.sv
// osm_ctrl: sequencer for the order-statistic multiset.
// Decodes each beat, drives the cell operation, keeps the key count and
// registers the result. Depends on osm_pkg.
module osm_ctrl
    import osm_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [1:0]                i_kind,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [RANK_W-1:0]         i_rank,
    input  logic                      i_any_match,
    input  logic [KEY_WIDTH-1:0]      i_head_key,
    output t_cell_op                  o_op,
    output logic [KEY_WIDTH-1:0]      o_key,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic [COUNT_W-1:0]        o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int EW = (CW > RANK_W) ? CW : RANK_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ERASE  = 2'd1;
    localparam logic [1:0] S_QLEFT  = 2'd2;
    localparam logic [1:0] S_QRIGHT = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_cnt, n_cnt;
    logic [IW-1:0]            r_rot, n_rot;
    logic [KEY_WIDTH-1:0]     r_key, n_key;
    logic                     r_done, n_done;
    logic [1:0]               r_status, n_status;
    logic [VALUE_W-1:0]       r_result, n_result;
    logic [COUNT_W-1:0]       r_ecount;
    logic                     w_accept;
    logic [KEY_WIDTH-1:0]     w_key_in;
    logic [RANK_W-1:0]        w_rank_eff;
    logic [VALUE_W-1:0]       w_head_val;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_key_in   = KEY_WIDTH'($unsigned(i_value));
    assign w_rank_eff = (i_rank == '0) ? RANK_W'(1) : i_rank;
    assign w_head_val = VALUE_W'(i_head_key);

    assign o_key          = (r_state == S_IDLE) ? w_key_in : r_key;
    assign o_count        = r_count;
    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_value = r_result;
    assign o_entry_count  = r_ecount;

    // Sequencing of one beat
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cnt    = r_cnt;
        n_rot    = r_rot;
        n_key    = r_key;
        n_done   = 1'b0;
        n_status = r_status;
        n_result = r_result;
        o_op     = OP_HOLD;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_INSERT: begin
                            n_done   = 1'b1;
                            n_result = '0;
                            if (r_count < CW'(CAPACITY)) begin
                                o_op     = OP_INSERT;
                                n_count  = r_count + CW'(1);
                                n_status = STAT_OK;
                            end else begin
                                n_status = STAT_FULL;
                            end
                        end
                        KIND_ERASE: begin
                            n_key   = w_key_in;
                            n_state = S_ERASE;
                        end
                        KIND_QUERY: begin
                            if (EW'(w_rank_eff) > EW'(r_count)) begin
                                n_done   = 1'b1;
                                n_status = STAT_RANGE;
                                n_result = '0;
                            end else if (w_rank_eff == RANK_W'(1)) begin
                                n_done   = 1'b1;
                                n_status = STAT_OK;
                                n_result = w_head_val;
                            end else begin
                                n_cnt   = IW'(w_rank_eff - RANK_W'(1));
                                n_rot   = IW'(w_rank_eff - RANK_W'(1));
                                n_state = S_QLEFT;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = STAT_OK;
                            n_result = '0;
                        end
                    endcase
                end
            end
            S_ERASE: begin
                // one copy removed per cycle until none is left
                if (i_any_match) begin
                    o_op    = OP_COMPACT;
                    n_count = r_count - CW'(1);
                end else begin
                    n_done   = 1'b1;
                    n_status = STAT_OK;
                    n_result = '0;
                    n_state  = S_IDLE;
                end
            end
            S_QLEFT: begin
                // rotate the wanted key to the head, then read it
                if (r_cnt != '0) begin
                    o_op  = OP_ROT_L;
                    n_cnt = r_cnt - IW'(1);
                end else begin
                    n_done   = 1'b1;
                    n_status = STAT_OK;
                    n_result = w_head_val;
                    n_cnt    = r_rot;
                    n_state  = S_QRIGHT;
                end
            end
            S_QRIGHT: begin
                // rotate back to restore the order
                o_op  = OP_ROT_R;
                n_cnt = r_cnt - IW'(1);
                if (r_cnt == IW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Operands and result beat
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rot <= n_rot;
        r_key <= n_key;
        if (n_done) begin
            r_status <= n_status;
            r_result <= n_result;
            r_ecount <= COUNT_W'(n_count);
        end
    end

endmodule

### design/order_statistic_multiset.sv
// order_statistic_multiset: top level, a chain of sorted key cells and
// its sequencer. Depends on osm_pkg, osm_cell and osm_ctrl.
//
// Keeps up to CAPACITY signed keys in descending order. An item is taken
// when start is high and busy is low; each item gives one result beat on
// o_done, one cycle long, which the receiver cannot hold off. Insert,
// unused kinds, rank-1 queries and out-of-range queries keep busy low and
// the result appears the cycle after the item, so one item per cycle.
// Erase closes the chain up by one slot per cycle until no copy is left,
// with busy high meanwhile. A query of rank r >= 2 rotates the chain r-1
// slots to the head, reads it, and rotates back; its result beat comes
// from the read while the chain rotates back, and busy stays high until
// the rotation back is done. The chain moves data one cell per cycle.
// Valid flags clear at reset, so no clearing pass is needed.
module order_statistic_multiset
    import osm_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_kind,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [RANK_W-1:0]         i_rank,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic [COUNT_W-1:0]        o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_cell_op             w_op;
    logic [KEY_WIDTH-1:0] w_op_key;
    logic [KEY_WIDTH-1:0] w_key [CAPACITY];
    logic [CAPACITY-1:0]  w_valid;
    logic [CAPACITY-1:0]  w_gt;
    logic [CAPACITY-1:0]  w_match;
    logic [CW-1:0]        w_count;

    osm_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_rank         (i_rank),
        .i_any_match    (|w_match),
        .i_head_key     (w_key[0]),
        .o_op           (w_op),
        .o_key          (w_op_key),
        .o_count        (w_count),
        .o_busy         (busy),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_entry_count  (o_entry_count)
    );

    // Cell chain, closed into a ring for rotation
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int PREV = (g == 0) ? CAPACITY - 1 : g - 1;
        localparam int NEXT = (g == CAPACITY - 1) ? 0 : g + 1;

        osm_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_key        (w_op_key),
            .i_prev_key   (w_key[PREV]),
            .i_prev_valid (w_valid[PREV]),
            .i_prev_gt    ((g == 0) ? 1'b1 : w_gt[PREV]),
            .i_next_key   (w_key[NEXT]),
            .i_next_valid (w_valid[NEXT]),
            .i_chain_end  ((g == CAPACITY - 1) ? 1'b1 : 1'b0),
            .o_key        (w_key[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g]),
            .o_match      (w_match[g])
        );
    end

    // Valid flags always agree with the key count
    a_count_matches_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(w_count)
    ) else $error("valid flags disagree with key count");

    // Between items the valid keys fill the chain from the head
    a_valid_prefix: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> ((w_valid & (w_valid + CAPACITY'(1))) == '0)
    ) else $error("valid keys not packed at the head");

    // A dropped insert only happens on a full store
    a_full_drop: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STAT_FULL)) |-> (int'(w_count) == CAPACITY)
    ) else $error("insert dropped while store not full");

endmodule

### sim/tb.sv
// tb: self-checking bench for order_statistic_multiset, driving insert, erase and
// query beats and comparing each result beat with a sorted-queue predictor.
// Depends on osm_pkg and the order_statistic_multiset RTL.
`timescale 1ns / 1ps

module tb;
    import osm_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int POOL_SIZE = 24;
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } t_item_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                i_kind = KIND_INSERT;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic [RANK_W-1:0]         i_rank = '0;
    logic                      o_done;
    logic [1:0]                o_status;
    logic signed [VALUE_W-1:0] o_result_value;
    logic [COUNT_W-1:0]        o_entry_count;

    // Predictor state: keys held in descending order
    logic signed [VALUE_W-1:0] held_keys[$];
    t_item_result              pending_results[$];
    logic signed [VALUE_W-1:0] key_pool[POOL_SIZE];
    int                        error_count = 0;
    bit                        sender_gaps = 1'b1;

    order_statistic_multiset #(
        .CAPACITY (STORE_DEPTH),
        .KEY_WIDTH(VALUE_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_rank        (i_rank),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_result_value(o_result_value),
        .o_entry_count (o_entry_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one beat to the held keys and work out its result
    function automatic t_item_result apply_to_multiset(logic [1:0] kind,
                                                       logic signed [VALUE_W-1:0] value,
                                                       logic [RANK_W-1:0] rank);
        t_item_result res;
        int pos;
        int want;
        res.status = STAT_OK;
        res.value  = '0;
        case (kind)
            KIND_INSERT: begin
                if (held_keys.size() >= STORE_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    // new key goes after every key that is not smaller
                    pos = 0;
                    while (pos < held_keys.size() && held_keys[pos] >= value) pos++;
                    held_keys.insert(pos, value);
                end
            end
            KIND_ERASE: begin
                for (int k = held_keys.size() - 1; k >= 0; k--)
                    if (held_keys[k] == value) held_keys.delete(k);
            end
            KIND_QUERY: begin
                want = (rank == 0) ? 1 : int'(rank);
                if (want > held_keys.size()) res.status = STAT_RANGE;
                else res.value = held_keys[want-1];
            end
            default: ;
        endcase
        res.count = COUNT_W'(held_keys.size());
        return res;
    endfunction

    // Predict on every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            pending_results.insert(pending_results.size(),
                                   apply_to_multiset(i_kind, i_value, i_rank));
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_item_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: status %0d value %0d count %0d",
                         $time, o_status, o_result_value, o_entry_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_result_value !== want.value) begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, want.value, o_result_value);
                    error_count++;
                end
                if (o_entry_count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                    error_count++;
                end
            end
        end
    end

    // Send one beat; returns at the edge where it is taken
    task automatic send_item(input logic [1:0] kind, input logic signed [VALUE_W-1:0] value,
                             input logic [RANK_W-1:0] rank);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        i_rank  <= rank;
        do @(posedge i_clk); while (busy);
    endtask

    // Mostly keys from a small pool so that duplicates and erase hits are common
    function automatic logic signed [VALUE_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_SIZE-1)];
        return $urandom;
    endfunction

    function automatic logic [RANK_W-1:0] pick_rank();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return RANK_W'($urandom_range(0, held_keys.size() + 1));
        if (sel < 7) return RANK_W'($urandom_range(0, 511));
        return RANK_W'($urandom_range(0, 8));
    endfunction

    task automatic send_random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) send_item(KIND_INSERT, pick_key(), RANK_W'($urandom));
        else if (sel < 55) send_item(KIND_ERASE, pick_key(), RANK_W'($urandom));
        else if (sel < 95) send_item(KIND_QUERY, $urandom, pick_rank());
        else send_item(KIND_UNUSED, $urandom, RANK_W'($urandom));
    endtask

    // Extremes, empty store, duplicates, rank zero, absent erase, unused kind
    task automatic test_directed();
        send_item(KIND_QUERY, 0, 9'd0);
        send_item(KIND_QUERY, 0, 9'd511);
        send_item(KIND_ERASE, 0, 9'd0);
        send_item(KIND_UNUSED, 32'h7fff_ffff, 9'd1);
        send_item(KIND_INSERT, 32'h7fff_ffff, 9'd0);
        send_item(KIND_INSERT, 32'h8000_0000, 9'd0);
        send_item(KIND_INSERT, 0, 9'd0);
        send_item(KIND_INSERT, -1, 9'd0);
        send_item(KIND_INSERT, 0, 9'd0);
        send_item(KIND_INSERT, 32'h7fff_ffff, 9'd0);
        send_item(KIND_QUERY, 0, 9'd0);
        send_item(KIND_QUERY, 0, 9'd1);
        send_item(KIND_QUERY, 0, 9'd6);
        send_item(KIND_QUERY, 0, 9'd7);
        send_item(KIND_QUERY, 0, 9'd3);
        send_item(KIND_ERASE, 0, 9'd0);
        send_item(KIND_ERASE, 5, 9'd0);
        send_item(KIND_QUERY, 0, 9'd4);
        send_item(KIND_QUERY, 0, 9'd5);
        send_item(KIND_UNUSED, $urandom, RANK_W'($urandom));
        send_item(KIND_ERASE, 32'h8000_0000, 9'd0);
        send_item(KIND_ERASE, 32'h7fff_ffff, 9'd0);
        send_item(KIND_QUERY, 0, 9'd1);
        send_item(KIND_ERASE, -1, 9'd0);
        send_item(KIND_QUERY, 0, 9'd256);
    endtask

    // Fill the store past capacity, probe the top ranks, then erase it empty
    task automatic test_full_store();
        repeat (STORE_DEPTH + 3)
            send_item(KIND_INSERT, key_pool[$urandom_range(0, POOL_SIZE-1)], RANK_W'($urandom));
        send_item(KIND_QUERY, $urandom, 9'd256);
        send_item(KIND_QUERY, $urandom, 9'd257);
        send_item(KIND_QUERY, $urandom, 9'd0);
        send_item(KIND_QUERY, $urandom, 9'd511);
        send_item(KIND_QUERY, $urandom, RANK_W'($urandom_range(2, 255)));
        send_item(KIND_UNUSED, $urandom, RANK_W'($urandom));
        for (int k = 0; k < POOL_SIZE; k++)
            send_item(KIND_ERASE, key_pool[k], RANK_W'($urandom));
        send_item(KIND_QUERY, $urandom, 9'd1);
    endtask

    // Random mix with gaps switched on and off in stretches
    task automatic test_random_mix(input int n_items);
        for (int k = 0; k < n_items; k++) begin
            if (k % 50 == 0) sender_gaps = $urandom_range(0, 2) != 0;
            send_random_item();
        end
    endtask

    // Same mix, beats back to back
    task automatic test_back_to_back(input int n_items);
        sender_gaps = 1'b0;
        repeat (n_items) send_random_item();
    endtask

    initial begin
        key_pool[0] = 32'h7fff_ffff;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 0;
        key_pool[3] = -1;
        for (int k = 4; k < POOL_SIZE; k++) key_pool[k] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_random_mix(750);
        test_back_to_back(150);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS order_statistic_multiset");
        else
            $display("FAIL order_statistic_multiset");
        $finish;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("FAIL order_statistic_multiset");
        $finish;
    end

endmodule

### order_statistic_multiset.f
design/osm_pkg.sv
design/osm_cell.sv
design/osm_ctrl.sv
design/order_statistic_multiset.sv
sim/tb.sv
